>>> hdl/sorted_key_value_table_core_assert.svh
// ----------------------------------------------------------------------------
// sorted key/value table assertion macros
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SKVT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted key/value table check failed");

// next-cycle implication, disabled during reset
`define SKVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted key/value table check failed");

`endif

>>> hdl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared constants, codes and types of the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic                  upd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/skvt_cell.sv
// ----------------------------------------------------------------------------
// skvt_cell
// One table entry: compares its key against the request key and takes data
// from its lower or upper neighbor when entries shift.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_ctl_t             ctl,
  input  wire logic                  lt_in,
  input  wire logic [KEY_BITS-1:0]   lo_key,
  input  wire logic [VALUE_BITS-1:0] lo_value,
  input  wire logic                  lo_valid,
  input  wire logic [KEY_BITS-1:0]   hi_key,
  input  wire logic [VALUE_BITS-1:0] hi_value,
  input  wire logic                  hi_valid,
  output logic [KEY_BITS-1:0]        cell_key,
  output logic [VALUE_BITS-1:0]      cell_value,
  output logic                       cell_valid,
  output logic                       lt,
  output logic                       eq,
  output logic                       mark
);

  // compare against the request key
  always_comb begin
    lt   = cell_valid && (cell_key < ctl.key);
    eq   = cell_valid && (cell_key == ctl.key);
    mark = !lt && lt_in;
  end

  // occupancy follows the shifting entries
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (ctl.ins && !lt) begin
      cell_valid <= mark ? 1'b1 : lo_valid;
    end else if (ctl.del && !lt) begin
      cell_valid <= hi_valid;
    end
  end

  // key and value: shift up on insert, down on delete, overwrite on hit
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      cell_key   <= mark ? ctl.key : lo_key;
      cell_value <= mark ? ctl.value : lo_value;
    end else if (ctl.del && !lt) begin
      cell_key   <= hi_key;
      cell_value <= hi_value;
    end else if (ctl.upd && eq) begin
      cell_value <= ctl.value;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sorted_key_value_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Fixed-capacity table of key/value pairs kept in ascending key order.
// ----------------------------------------------------------------------------
// Usage:
//   A request (kind, key, value) is taken at a rising edge where start is
//   high and busy is low. kind selects insert, delete or find.
//   busy is high for one cycle while the row of cells compares every stored
//   key against the request key and shifts entries in place.
//   The result (status, found_value, position, entry_count) is shown with
//   done high for exactly one cycle, the cycle after busy. A new request
//   may be given in the cycle done is high; start is ignored while busy
//   is high, so a request is taken only once the last one has left the
//   compare-and-shift of the cell row after the request register.
//   The receiver cannot stall: results must be taken as they appear.
//   Reset empties the table (all cells invalid, count zero); stored keys
//   and values are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_value_table_core_assert.svh"

module sorted_key_value_table_core
  import skvt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [1:0]            kind,
  input  wire logic [KEY_BITS-1:0]   key,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       busy,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [VALUE_BITS-1:0]      found_value,
  output logic [POS_BITS-1:0]        position,
  output logic [CNT_BITS-1:0]        entry_count
);

  op_t                   req_kind;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;

  cell_ctl_t             ctl;
  logic                  hit;
  logic                  full;
  logic [POS_BITS-1:0]   slot_pos;
  logic [VALUE_BITS-1:0] hit_value;
  status_t               status_next;
  logic [VALUE_BITS-1:0] found_value_next;
  logic [POS_BITS-1:0]   position_next;

  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   mark_vec;

  // request register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (busy) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_kind  <= op_t'(kind);
      req_key   <= key;
      req_value <= value;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  lt_in;
    logic [KEY_BITS-1:0]   lo_key;
    logic [VALUE_BITS-1:0] lo_value;
    logic                  lo_valid;
    logic [KEY_BITS-1:0]   hi_key;
    logic [VALUE_BITS-1:0] hi_value;
    logic                  hi_valid;

    if (i == 0) begin : g_first
      assign lt_in    = 1'b1;
      assign lo_key   = '0;
      assign lo_value = '0;
      assign lo_valid = 1'b0;
    end else begin : g_mid_lo
      assign lt_in    = lt_vec[i-1];
      assign lo_key   = cell_key[i-1];
      assign lo_value = cell_value[i-1];
      assign lo_valid = valid_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign hi_key   = '0;
      assign hi_value = '0;
      assign hi_valid = 1'b0;
    end else begin : g_mid_hi
      assign hi_key   = cell_key[i+1];
      assign hi_value = cell_value[i+1];
      assign hi_valid = valid_vec[i+1];
    end

    skvt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .lt_in      (lt_in),
      .lo_key     (lo_key),
      .lo_value   (lo_value),
      .lo_valid   (lo_valid),
      .hi_key     (hi_key),
      .hi_value   (hi_value),
      .hi_valid   (hi_valid),
      .cell_key   (cell_key[i]),
      .cell_value (cell_value[i]),
      .cell_valid (valid_vec[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i]),
      .mark       (mark_vec[i])
    );
  end

  // match, slot encode and matched value
  always_comb begin
    hit       = |eq_vec;
    full      = (count == CNT_BITS'(CAPACITY));
    slot_pos  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mark_vec[i]) begin
        slot_pos = slot_pos | POS_BITS'(i);
      end
      if (eq_vec[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  // cell controls and result values
  always_comb begin
    ctl.ins          = 1'b0;
    ctl.del          = 1'b0;
    ctl.upd          = 1'b0;
    ctl.key          = req_key;
    ctl.value        = req_value;
    status_next      = ST_OK;
    found_value_next = '0;
    position_next    = '0;
    count_next       = count;
    unique case (req_kind)
      OP_INSERT: begin
        if (hit) begin
          ctl.upd       = busy;
          position_next = slot_pos;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins       = busy;
          position_next = slot_pos;
          count_next    = count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          ctl.del       = busy;
          position_next = slot_pos;
          count_next    = count - 1'b1;
        end else begin
          status_next = ST_MISSING;
        end
      end
      OP_FIND: begin
        if (hit) begin
          found_value_next = hit_value;
          position_next    = slot_pos;
        end else begin
          status_next = ST_MISSING;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // entry count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy;
      if (busy) begin
        count <= count_next;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (busy) begin
      status      <= status_next;
      found_value <= found_value_next;
      position    <= position_next;
    end
  end

  assign entry_count = count;

  // checks
  `SKVT_ASSERT_NEXT(a_busy_then_done, clk, rst, busy, done && !busy)
  `SKVT_ASSERT_NEXT(a_request_sets_busy, clk, rst, start && !busy, busy)
  `SKVT_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_BITS'(CAPACITY))
  `SKVT_ASSERT_SAME(a_valid_matches_count, clk, rst, 1'b1, $countones(valid_vec) == int'(count))

endmodule

`default_nettype wire
